@@ sv/vfbs_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vfbs_pkg: shared types and constants
// Constants, request codes and beat layouts for the voxel face bitmap store.
// ---------------------------------------------------------------------------
package vfbs_pkg;

   localparam int AXIS_MAX   = 32;
   localparam int WORD_BITS  = 16;
   localparam int DIRECTIONS = 6;
   localparam int ROW_WORDS  = (AXIS_MAX + WORD_BITS - 1) / WORD_BITS;
   localparam int DEPTH      = DIRECTIONS * AXIS_MAX * AXIS_MAX * ROW_WORDS;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int CNT_W      = 18;
   localparam int WIDE_W     = 40;

   typedef enum logic [2:0] {
      REQ_SET     = 3'd0,
      REQ_HAS     = 3'd1,
      REQ_READ    = 3'd2,
      REQ_WRITE   = 3'd3,
      REQ_REPLACE = 3'd4,
      REQ_EMIT    = 3'd5
   } req_code_type;

   typedef enum logic [1:0] {
      CSR_AXIS   = 2'd0,
      CSR_ROOT_X = 2'd1,
      CSR_ROOT_Y = 2'd2,
      CSR_ROOT_Z = 2'd3
   } csr_code_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [2:0]  direction;
      logic [31:0] cell_x;
      logic [31:0] cell_y;
      logic [31:0] cell_z;
      logic [4:0]  slice;
      logic [4:0]  row_v;
      logic        word_index;
      logic [15:0] data_word;
      logic [15:0] mask_word;
   } req_type_type;

   typedef struct packed {
      logic        hit;
      logic [15:0] read_word;
      logic [31:0] face_x;
      logic [31:0] face_y;
      logic [31:0] face_z;
      logic [2:0]  face_dir;
      logic        face_valid;
      logic [17:0] total_faces;
      logic        error;
      logic        last;
   } rsp_type_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [31:0] data;
   } csr_type_type;

   // popcount of one word
   function automatic logic [BIT_W:0] popcnt(input logic [WORD_BITS-1:0] w);
      logic [BIT_W:0] c;
      c = '0;
      for (int i = 0; i < WORD_BITS; i++) c = c + (BIT_W+1)'(w[i]);
      return c;
   endfunction

endpackage

@@ sv/vfbs_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vfbs_if: valid/ready channels
// Request, response and register-write channels.
// ---------------------------------------------------------------------------
interface vfbs_req_if;
   logic valid;
   logic ready;
   vfbs_pkg::req_type_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface vfbs_rsp_if;
   logic valid;
   logic ready;
   vfbs_pkg::rsp_type_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface vfbs_csr_if;
   logic valid;
   logic ready;
   vfbs_pkg::csr_type_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ sv/vfbs_mem.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vfbs_mem: plane word store
// Single-port word memory with registered read data.
// ---------------------------------------------------------------------------
module vfbs_mem (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [vfbs_pkg::ADDR_W-1:0]         addr,
   input  logic [vfbs_pkg::WORD_BITS-1:0]      wr_data,
   output logic [vfbs_pkg::WORD_BITS-1:0]      rd_data
);
   logic [vfbs_pkg::WORD_BITS-1:0] mem [vfbs_pkg::DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule

@@ sv/vfbs_mac.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vfbs_mac: shared multiply-add unit
// One registered a*b+c: 32-bit signed a, 7-bit unsigned b, 40-bit signed c and result, 32x7 product.
// ---------------------------------------------------------------------------
module vfbs_mac (
   input  logic                                  clock,
   input  logic signed [31:0]                    op_a,
   input  logic        [6:0]                     op_b,
   input  logic signed [vfbs_pkg::WIDE_W-1:0]    op_c,
   output logic signed [vfbs_pkg::WIDE_W-1:0]    res_ff
);
   logic signed [vfbs_pkg::WIDE_W-1:0] res_in;

   assign res_in = vfbs_pkg::WIDE_W'(op_a) * vfbs_pkg::WIDE_W'($signed({1'b0, op_b}))
                   + op_c;

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end
endmodule

@@ sv/voxel_face_bitmap_store_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// voxel_face_bitmap_store_core: voxel face bitmap store
// Face bitmap in a plane word memory, driven by a small sequencer and one
// shared multiply-add unit.
// ---------------------------------------------------------------------------
// channel | dir | ports               | beat
// req     | in  | req_valid/req_ready | one request
// rsp     | out | rsp_valid/rsp_ready | one result, last on final beat
// csr     | in  | csr_valid/csr_ready | one register write
//
// Sequence: every request walks the shared multiply-add: root scaling
// (S_RX, S_RY, S_RZ; contains and emit only), address (S_A1, S_A2), memory
// read (S_RD), then one response beat; emit sends one beat per qualifying
// bit, or a single error beat if any emitted face overflows 32 bits.
// Reset: the memory is cleared after reset, one word per cycle, all DEPTH
// (12288) words, with req_ready low; csr writes are taken throughout.
// Stalls: the response register holds while rsp_ready is low; no new
// request is taken until the last beat leaves.
// ---------------------------------------------------------------------------
module voxel_face_bitmap_store_core (
   input  logic           clock,
   input  logic           reset,
   vfbs_req_if.sink       req,
   vfbs_rsp_if.source     rsp,
   vfbs_csr_if.sink       csr
);
   localparam int AW = vfbs_pkg::ADDR_W;
   localparam int WB = vfbs_pkg::WORD_BITS;
   localparam int WW = vfbs_pkg::WIDE_W;

   typedef enum logic [10:0] {
      S_CLEAR = 11'b00000000001,
      S_IDLE  = 11'b00000000010,
      S_RX    = 11'b00000000100,
      S_RY    = 11'b00000001000,
      S_RZ    = 11'b00000010000,
      S_CHK   = 11'b00000100000,
      S_A1    = 11'b00001000000,
      S_A2    = 11'b00010000000,
      S_RD    = 11'b00100000000,
      S_EXEC  = 11'b01000000000,
      S_OUT   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // registers
   logic [5:0]  axis_ff, axis_in;
   logic [31:0] rootx_ff, rootx_in, rooty_ff, rooty_in, rootz_ff, rootz_in;
   logic [vfbs_pkg::CNT_W-1:0] count_ff, count_in;

   vfbs_pkg::req_type_type q_ff, q_in;
   logic signed [WW-1:0] mx_ff, mx_in, my_ff, my_in, mz_ff, mz_in;
   logic [AW:0]  clr_ff, clr_in;
   logic [WB-1:0] scan_ff, scan_in;
   logic [WB-1:0] vm_ff, vm_in;
   logic [4:0]  sl_ff, sl_in, v_ff, v_in;
   logic        wi_ff, wi_in;
   logic [3:0]  ub_ff, ub_in;
   logic        bad_ff, bad_in;
   logic        rsp_valid_ff, rsp_valid_in;
   vfbs_pkg::rsp_type_type rsp_ff, rsp_in;

   // shared unit
   logic signed [31:0]  mac_a;
   logic [6:0]          mac_b;
   logic signed [WW-1:0] mac_c, mac_r;

   vfbs_mac u_mac (.clock(clock), .op_a(mac_a), .op_b(mac_b), .op_c(mac_c), .res_ff(mac_r));

   // memory
   logic          mem_we;
   logic [AW-1:0] mem_addr, addr_ff, addr_in;
   logic [WB-1:0] mem_wd, mem_rd;

   vfbs_mem u_mem (.clock(clock), .wr_en(mem_we), .addr(mem_addr), .wr_data(mem_wd),
                   .rd_data(mem_rd));

   logic axis_ok, dir_ok, rw_cnt;
   assign axis_ok = (axis_ff != 6'd0) && (axis_ff <= 6'(vfbs_pkg::AXIS_MAX));
   assign dir_ok  = q_ff.direction < 3'(vfbs_pkg::DIRECTIONS);
   assign rw_cnt  = axis_ff > 6'(WB);  // two words per row

   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   // local range check on 40-bit value
   function automatic logic in_axis(input logic signed [WW-1:0] c, input logic [5:0] a);
      return (c >= 0) && (c < WW'(a));
   endfunction

   function automatic logic fits32(input logic signed [WW-1:0] c);
      return (c <= WW'(32'sh7fffffff)) && (c >= -WW'(64'sh80000000));
   endfunction

   logic signed [WW-1:0] lx, ly, lz;
   logic [4:0] p_sl, p_u, p_v;
   logic [3:0] low_bit;
   logic [WB-1:0] nw, m_msk, d_msk, diff;
   logic [vfbs_pkg::BIT_W:0] oc, nc;
   logic signed [WW-1:0] gx, gy, gz;
   logic [4:0] eu;

   always_comb begin
      low_bit = '0;
      for (int i = WB - 1; i >= 0; i--) if (scan_ff[i]) low_bit = 4'(i);
   end

   always_comb begin
      lx = $signed(WW'($signed(q_ff.cell_x))) - mx_ff;
      ly = $signed(WW'($signed(q_ff.cell_y))) - my_ff;
      lz = $signed(WW'($signed(q_ff.cell_z))) - mz_ff;
      unique case (q_ff.direction[2:1])
         2'd0:    begin p_sl = lx[4:0]; p_u = ly[4:0]; p_v = lz[4:0]; end
         2'd1:    begin p_sl = ly[4:0]; p_u = lx[4:0]; p_v = lz[4:0]; end
         default: begin p_sl = lz[4:0]; p_u = lx[4:0]; p_v = ly[4:0]; end
      endcase
      eu = {wi_ff, low_bit};
      unique case (q_ff.direction[2:1])
         2'd0: begin
            gx = mx_ff + WW'(sl_ff); gy = my_ff + WW'(eu); gz = mz_ff + WW'(v_ff);
         end
         2'd1: begin
            gx = mx_ff + WW'(eu); gy = my_ff + WW'(sl_ff); gz = mz_ff + WW'(v_ff);
         end
         default: begin
            gx = mx_ff + WW'(eu); gy = my_ff + WW'(v_ff); gz = mz_ff + WW'(sl_ff);
         end
      endcase
      m_msk = q_ff.mask_word & vm_ff;
      d_msk = q_ff.data_word & vm_ff;
      nw    = (mem_rd & ~m_msk) | (d_msk & m_msk);
      oc    = vfbs_pkg::popcnt(mem_rd & m_msk);
      nc    = vfbs_pkg::popcnt(nw & m_msk);
      diff  = mem_rd & ~q_ff.mask_word & vm_ff;
   end

   always_comb begin
      state_in = state_ff;
      axis_in = axis_ff; rootx_in = rootx_ff; rooty_in = rooty_ff; rootz_in = rootz_ff;
      count_in = count_ff; q_in = q_ff;
      mx_in = mx_ff; my_in = my_ff; mz_in = mz_ff;
      clr_in = clr_ff; scan_in = scan_ff; vm_in = vm_ff;
      sl_in = sl_ff; v_in = v_ff; wi_in = wi_ff; ub_in = ub_ff; bad_in = bad_ff;
      addr_in = addr_ff;
      rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      mac_a = '0; mac_b = '0; mac_c = '0;
      mem_we = 1'b0; mem_addr = addr_ff; mem_wd = '0;

      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;

      if (csr.valid) begin
         unique case (csr.data.index)
            vfbs_pkg::CSR_AXIS:   axis_in  = csr.data.data[5:0];
            vfbs_pkg::CSR_ROOT_X: rootx_in = csr.data.data;
            vfbs_pkg::CSR_ROOT_Y: rooty_in = csr.data.data;
            default:              rootz_in = csr.data.data;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1; mem_addr = clr_ff[AW-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(vfbs_pkg::DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid) begin
               q_in = req.data;
               mx_in = '0; my_in = '0; mz_in = '0;
               if (req.data.req_type == vfbs_pkg::REQ_HAS ||
                   req.data.req_type == vfbs_pkg::REQ_EMIT) state_in = S_RX;
               else state_in = S_CHK;
            end
         end
         S_RX: begin
            mac_a = rootx_ff; mac_b = {1'b0, axis_ff}; state_in = S_RY;
         end
         S_RY: begin
            mx_in = mac_r; mac_a = rooty_ff; mac_b = {1'b0, axis_ff}; state_in = S_RZ;
         end
         S_RZ: begin
            my_in = mac_r; mac_a = rootz_ff; mac_b = {1'b0, axis_ff}; state_in = S_CHK;
         end
         S_CHK: begin
            if (q_ff.req_type == vfbs_pkg::REQ_HAS) mz_in = mac_r;
            if (q_ff.req_type == vfbs_pkg::REQ_EMIT) mz_in = mac_r;
            state_in = S_A1;
         end
         S_A1: begin
            // pick plane coordinates and check them
            if (q_ff.req_type == vfbs_pkg::REQ_SET || q_ff.req_type == vfbs_pkg::REQ_HAS) begin
               sl_in = p_sl; v_in = p_v; wi_in = p_u[4]; ub_in = p_u[3:0];
               bad_in = !axis_ok || !dir_ok || !in_axis(lx, axis_ff) ||
                        !in_axis(ly, axis_ff) || !in_axis(lz, axis_ff) ||
                        (p_u[4] && !rw_cnt);
            end else begin
               sl_in = q_ff.slice; v_in = q_ff.row_v; wi_in = q_ff.word_index;
               ub_in = '0;
               bad_in = !axis_ok || !dir_ok || q_ff.req_type > vfbs_pkg::REQ_EMIT ||
                        {1'b0, q_ff.slice} >= axis_ff || {1'b0, q_ff.row_v} >= axis_ff ||
                        (q_ff.word_index && !rw_cnt);
            end
            // (dir*A + slice)
            mac_a = 32'(q_ff.direction);
            mac_b = {1'b0, axis_ff};
            mac_c = (q_ff.req_type == vfbs_pkg::REQ_SET || q_ff.req_type == vfbs_pkg::REQ_HAS) ?
                    WW'(p_sl) : WW'(q_ff.slice);
            state_in = S_A2;
         end
         S_A2: begin
            mac_a = 32'(mac_r);
            mac_b = {1'b0, axis_ff};
            mac_c = WW'(v_ff);
            // valid mask of this word
            if (!wi_ff && rw_cnt) vm_in = '1;
            else if (axis_ff - (wi_ff ? 6'(WB) : 6'd0) >= 6'(WB)) vm_in = '1;
            else vm_in = WB'((17'd1 << (axis_ff - (wi_ff ? 6'(WB) : 6'd0))) - 17'd1);
            state_in = S_RD;
         end
         S_RD: begin
            addr_in = rw_cnt ? AW'({mac_r[AW-2:0], wi_ff}) : AW'(mac_r);
            mem_addr = addr_in;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            rsp_in = '0;
            rsp_in.last = 1'b1;
            state_in = S_OUT;
            if (q_ff.req_type == vfbs_pkg::REQ_HAS) begin
               rsp_in.hit = !bad_ff && mem_rd[ub_ff];
            end else if (bad_ff) begin
               rsp_in.error = 1'b1;
            end else begin
               unique case (q_ff.req_type)
                  vfbs_pkg::REQ_SET: begin
                     if (!mem_rd[ub_ff]) begin
                        mem_we = 1'b1; mem_wd = mem_rd | (WB'(1) << ub_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  vfbs_pkg::REQ_READ: rsp_in.read_word = mem_rd;
                  vfbs_pkg::REQ_WRITE: begin
                     if ((q_ff.data_word & ~vm_ff) != '0) rsp_in.error = 1'b1;
                     else if (q_ff.data_word != '0) begin
                        if (mem_rd != '0) rsp_in.error = 1'b1;
                        else begin
                           mem_we = 1'b1; mem_wd = q_ff.data_word;
                           count_in = count_ff + vfbs_pkg::CNT_W'(
                                      vfbs_pkg::popcnt(q_ff.data_word));
                        end
                     end
                  end
                  vfbs_pkg::REQ_REPLACE: begin
                     if (m_msk != '0) begin
                        if (nc < oc && count_ff < vfbs_pkg::CNT_W'(oc - nc))
                           rsp_in.error = 1'b1;
                        else begin
                           mem_we = 1'b1; mem_wd = nw;
                           count_in = count_ff + vfbs_pkg::CNT_W'(nc) -
                                      vfbs_pkg::CNT_W'(oc);
                        end
                     end
                  end
                  default: begin
                     // emit: scan the difference, one face per beat
                     scan_in = diff;
                     if (diff != '0) begin
                        rsp_in.last = 1'b0;
                        state_in = S_OUT;
                     end
                  end
               endcase
            end
            rsp_valid_in = (q_ff.req_type != vfbs_pkg::REQ_EMIT) || bad_ff || diff == '0;
            if (!rsp_valid_in) state_in = S_OUT;
            rsp_in.total_faces = count_in;
            if (q_ff.req_type == vfbs_pkg::REQ_EMIT && !bad_ff && diff != '0) begin
               // overflow pre-check over every set bit uses first pass below
               bad_in = 1'b0;
               ub_in = '0;
            end
         end
         S_OUT: begin
            if (q_ff.req_type == vfbs_pkg::REQ_EMIT && scan_ff != '0 && !rsp_valid_ff) begin
               if (!ub_ff[0]) begin
                  // overflow pass: check every emitted face
                  if (!fits32(gx) || !fits32(gy) || !fits32(gz)) bad_in = 1'b1;
                  scan_in = scan_ff & (scan_ff - 1'b1);
                  if ((scan_ff & (scan_ff - 1'b1)) == '0) begin
                     ub_in = 4'd1;
                     scan_in = diff;
                     if (bad_in || bad_ff) begin
                        rsp_in = '0; rsp_in.error = 1'b1; rsp_in.last = 1'b1;
                        rsp_in.total_faces = count_ff;
                        rsp_valid_in = 1'b1; scan_in = '0;
                     end
                  end
               end else begin
                  rsp_in = '0;
                  rsp_in.face_x = gx[31:0]; rsp_in.face_y = gy[31:0];
                  rsp_in.face_z = gz[31:0];
                  rsp_in.face_dir = q_ff.direction; rsp_in.face_valid = 1'b1;
                  rsp_in.total_faces = count_ff;
                  scan_in = scan_ff & (scan_ff - 1'b1);
                  rsp_in.last = (scan_in == '0);
                  rsp_valid_in = 1'b1;
               end
            end else if (!rsp_valid_ff || rsp.ready) begin
               if (!(q_ff.req_type == vfbs_pkg::REQ_EMIT && scan_ff != '0)) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         axis_ff <= 6'd32;
         rootx_ff <= '0; rooty_ff <= '0; rootz_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         axis_ff <= axis_in;
         rootx_ff <= rootx_in; rooty_ff <= rooty_in; rootz_ff <= rootz_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; mx_ff <= mx_in; my_ff <= my_in; mz_ff <= mz_in;
      scan_ff <= scan_in; vm_ff <= vm_in; sl_ff <= sl_in; v_ff <= v_in;
      wi_ff <= wi_in; ub_ff <= ub_in; bad_ff <= bad_in; addr_ff <= addr_in;
      rsp_ff <= rsp_in;
   end
endmodule

@@ sv/vfbs_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vfbs_checker: port checks
// Watches the top-level ports for handshake and sequencing slips.
// ---------------------------------------------------------------------------
module vfbs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last,
   input logic rsp_face_valid,
   input logic rsp_error
);
   // stalled response beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped");

   // no new request while a response is pending
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken with response pending");

   // an error beat is always the last one and carries no face
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last && !rsp_face_valid)
      else $error("error beat malformed");

   // request accept closes the ready window
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("back-to-back requests");
endmodule

bind voxel_face_bitmap_store_core vfbs_checker u_vfbs_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_last(rsp.data.last), .rsp_face_valid(rsp.data.face_valid),
   .rsp_error(rsp.data.error)
);

@@ verif/voxel_face_bitmap_store_core_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// voxel_face_bitmap_store_core_tb: self-checking bench for the face store
// Drives requests and register writes over valid/ready channels, predicts
// every response beat from a bit-exact model of the store and checks each
// returned beat field by field, under random idling on both sides.
// ---------------------------------------------------------------------------
import vfbs_pkg::*;

// Shadow of the store: face bitmap, face count and registers, plus the
// queue of response beats still owed by the block.
class FaceStoreModel;
   logic [15:0]  words [DEPTH];
   int unsigned  count;
   logic [5:0]   axis;
   logic [31:0]  root_x, root_y, root_z;
   rsp_type_type owed_beats [$];
   int           errors;

   function new();
      foreach (words[i]) words[i] = '0;
      count  = 0;
      axis   = 6'd32;
      root_x = '0;
      root_y = '0;
      root_z = '0;
      errors = 0;
   endfunction

   function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
         CSR_AXIS:   axis   = v[5:0];
         CSR_ROOT_X: root_x = v;
         CSR_ROOT_Y: root_y = v;
         CSR_ROOT_Z: root_z = v;
         default: ;
      endcase
   endfunction

   function bit axis_ok();
      return axis >= 1 && axis <= AXIS_MAX;
   endfunction

   function int row_words();
      return (int'(axis) + WORD_BITS - 1) / WORD_BITS;
   endfunction

   function bit addr_of(int dir, int sl, int v, int wi, output int idx);
      int a;
      a   = axis;
      idx = 0;
      if (!axis_ok() || dir >= DIRECTIONS || sl >= a || v >= a || wi >= row_words())
         return 0;
      idx = ((dir * a + sl) * a + v) * row_words() + wi;
      return idx < DEPTH;
   endfunction

   function logic [15:0] valid_bits(int wi);
      int used;
      if (wi + 1 < row_words()) return 16'hFFFF;
      used = int'(axis) - wi * WORD_BITS;
      if (used >= WORD_BITS) return 16'hFFFF;
      return (16'd1 << used) - 16'd1;
   endfunction

   function bit in_cube(longint c);
      return c >= 0 && c < longint'(axis);
   endfunction

   function void push_beat(bit hit, logic [15:0] rw, longint x, longint y, longint z,
                           logic [2:0] dir, bit fv, bit err, bit last);
      rsp_type_type b;
      b.hit         = hit;
      b.read_word   = rw;
      b.face_x      = x[31:0];
      b.face_y      = y[31:0];
      b.face_z      = z[31:0];
      b.face_dir    = dir;
      b.face_valid  = fv;
      b.total_faces = count[17:0];
      b.error       = err;
      b.last        = last;
      owed_beats.push_back(b);
   endfunction

   function void note_request(req_type_type r);
      longint a, mx, my, mz, cx, cy, cz, lx, ly, lz;
      longint gx [16], gy [16], gz [16];
      int dir, s, u, v, idx, n, wi, oc, nc;
      logic [15:0] vm, d, m, nw, diff;
      bit hit, err;
      a   = longint'(axis);
      mx  = longint'($signed(root_x)) * a;
      my  = longint'($signed(root_y)) * a;
      mz  = longint'($signed(root_z)) * a;
      dir = r.direction;
      cx  = longint'($signed(r.cell_x));
      cy  = longint'($signed(r.cell_y));
      cz  = longint'($signed(r.cell_z));
      if (r.req_type == REQ_SET || r.req_type == REQ_HAS) begin
         hit = 0;
         err = 0;
         if (r.req_type == REQ_HAS) begin
            lx = cx - mx;
            ly = cy - my;
            lz = cz - mz;
         end else begin
            lx = cx;
            ly = cy;
            lz = cz;
         end
         if (!axis_ok() || dir >= DIRECTIONS || !in_cube(lx) || !in_cube(ly) ||
             !in_cube(lz)) begin
            err = (r.req_type == REQ_SET);
         end else begin
            case (dir >> 1)
               0:       begin s = lx; u = ly; v = lz; end
               1:       begin s = ly; u = lx; v = lz; end
               default: begin s = lz; u = lx; v = ly; end
            endcase
            if (!addr_of(dir, s, v, u / WORD_BITS, idx)) begin
               err = (r.req_type == REQ_SET);
            end else if (r.req_type == REQ_HAS) begin
               hit = words[idx][u % WORD_BITS];
            end else if (!words[idx][u % WORD_BITS]) begin
               words[idx][u % WORD_BITS] = 1'b1;
               count++;
            end
         end
         push_beat(hit, '0, 0, 0, 0, '0, 0, err, 1);
         return;
      end
      wi = r.word_index;
      if (r.req_type > REQ_EMIT || !addr_of(dir, r.slice, r.row_v, wi, idx)) begin
         push_beat(0, '0, 0, 0, 0, '0, 0, 1, 1);
         return;
      end
      vm = valid_bits(wi);
      case (r.req_type)
         REQ_READ: push_beat(0, words[idx], 0, 0, 0, '0, 0, 0, 1);
         REQ_WRITE: begin
            err = 0;
            if ((r.data_word & ~vm) != 0) err = 1;
            else if (r.data_word != 0) begin
               if (words[idx] != 0) err = 1;
               else begin
                  words[idx] = r.data_word;
                  count += $countones(r.data_word);
               end
            end
            push_beat(0, '0, 0, 0, 0, '0, 0, err, 1);
         end
         REQ_REPLACE: begin
            err = 0;
            m   = r.mask_word & vm;
            d   = r.data_word & vm;
            if (m != 0) begin
               nw = (words[idx] & ~m) | (d & m);
               oc = $countones(words[idx] & m);
               nc = $countones(nw & m);
               if (nc < oc && count < oc - nc) err = 1;
               else begin
                  count      = count + nc - oc;
                  words[idx] = nw;
               end
            end
            push_beat(0, '0, 0, 0, 0, '0, 0, err, 1);
         end
         default: begin
            // emit difference: lowest bit first, any overflow kills the lot
            diff = words[idx] & ~r.mask_word & vm;
            n    = 0;
            for (int b = 0; b < WORD_BITS; b++) begin
               if (diff[b]) begin
                  u = wi * WORD_BITS + b;
                  case (dir >> 1)
                     0:       begin lx = r.slice; ly = u; lz = r.row_v; end
                     1:       begin lx = u; ly = r.slice; lz = r.row_v; end
                     default: begin lx = u; ly = r.row_v; lz = r.slice; end
                  endcase
                  gx[n] = mx + lx;
                  gy[n] = my + ly;
                  gz[n] = mz + lz;
                  if (gx[n] > 64'sd2147483647 || gx[n] < -64'sd2147483648 ||
                      gy[n] > 64'sd2147483647 || gy[n] < -64'sd2147483648 ||
                      gz[n] > 64'sd2147483647 || gz[n] < -64'sd2147483648) begin
                     push_beat(0, '0, 0, 0, 0, '0, 0, 1, 1);
                     return;
                  end
                  n++;
               end
            end
            if (n == 0) push_beat(0, '0, 0, 0, 0, '0, 0, 0, 1);
            for (int k = 0; k < n; k++)
               push_beat(0, '0, gx[k], gy[k], gz[k], r.direction, 1, 0, k == n - 1);
         end
      endcase
   endfunction

   function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endfunction

   function void check_beat(rsp_type_type g);
      rsp_type_type e;
      if (owed_beats.size() == 0) begin
         $error("response beat with nothing owed: %p", g);
         errors++;
         return;
      end
      e = owed_beats.pop_front();
      cmp("hit", e.hit, g.hit);
      cmp("read_word", e.read_word, g.read_word);
      cmp("face_x", e.face_x, g.face_x);
      cmp("face_y", e.face_y, g.face_y);
      cmp("face_z", e.face_z, g.face_z);
      cmp("face_dir", e.face_dir, g.face_dir);
      cmp("face_valid", e.face_valid, g.face_valid);
      cmp("total_faces", e.total_faces, g.total_faces);
      cmp("error", e.error, g.error);
      cmp("last", e.last, g.last);
   endfunction
endclass

module voxel_face_bitmap_store_core_tb;

   logic clock;
   logic reset;

   vfbs_req_if req ();
   vfbs_rsp_if rsp ();
   vfbs_csr_if csr ();

   voxel_face_bitmap_store_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   FaceStoreModel store = new();

   // idle percentages for each side, changed by the main sequence
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   // long receiver hold: main raises hold_go, the ready process counts it out
   bit hold_go     = 0;
   int hold_left   = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // all inputs known from time zero
   initial begin
      reset     = 1'b1;
      req.valid = 1'b0;
      req.data  = '0;
      csr.valid = 1'b0;
      csr.data  = '0;
      rsp.ready = 1'b0;
   end

   // Receiver: random ready, or held low for a counted stretch.
   always @(posedge clock) begin
      if (hold_go && hold_left == 0) begin
         hold_left = 400;
         hold_go   = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Monitors sample pre-edge values; drivers only change after the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) store.note_request(req.data);
         if (rsp.valid && rsp.ready) store.check_beat(rsp.data);
         if (csr.valid && csr.ready) store.set_reg(csr.data.index, csr.data.data);
      end
   end

   // One request beat; valid stays high across back-to-back beats.
   task automatic send_req(req_type_type r);
      while ($urandom_range(99) < tx_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data  <= r;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic write_reg(csr_code_type idx, logic [31:0] v);
      csr.valid      <= 1'b1;
      csr.data.index <= idx;
      csr.data.data  <= v;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
   endtask

   // Drop valid, let every owed beat come home, then a short settle.
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (store.owed_beats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic configure(logic [5:0] a, logic [31:0] x, logic [31:0] y, logic [31:0] z);
      write_reg(CSR_AXIS, {26'd0, a});
      write_reg(CSR_ROOT_X, x);
      write_reg(CSR_ROOT_Y, y);
      write_reg(CSR_ROOT_Z, z);
   endtask

   function automatic req_type_type plain(logic [2:0] op, logic [2:0] dir);
      req_type_type r;
      r           = '0;
      r.req_type  = op;
      r.direction = dir;
      return r;
   endfunction

   // Random request: mostly in range for the current cube, some noise.
   function automatic req_type_type make_item();
      req_type_type r;
      int span, pick;
      longint a;
      span = (store.axis >= 1 && store.axis <= AXIS_MAX) ? store.axis - 1 : 31;
      a    = longint'(store.axis);
      r    = '0;
      if ($urandom_range(9) == 0) begin
         r.req_type   = $urandom_range(7);
         r.direction  = $urandom_range(7);
         r.cell_x     = $urandom;
         r.cell_y     = $urandom;
         r.cell_z     = $urandom;
         r.slice      = $urandom;
         r.row_v      = $urandom;
         r.word_index = $urandom;
         r.data_word  = $urandom;
         r.mask_word  = $urandom;
         return r;
      end
      pick = $urandom_range(99);
      if (pick < 30)      r.req_type = REQ_SET;
      else if (pick < 45) r.req_type = REQ_HAS;
      else if (pick < 55) r.req_type = REQ_READ;
      else if (pick < 67) r.req_type = REQ_WRITE;
      else if (pick < 80) r.req_type = REQ_REPLACE;
      else                r.req_type = REQ_EMIT;
      r.direction  = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
      r.cell_x     = $urandom_range(span);
      r.cell_y     = $urandom_range(span);
      r.cell_z     = $urandom_range(span);
      if (r.req_type == REQ_HAS) begin
         r.cell_x = 32'(longint'($signed(store.root_x)) * a + longint'(r.cell_x));
         r.cell_y = 32'(longint'($signed(store.root_y)) * a + longint'(r.cell_y));
         r.cell_z = 32'(longint'($signed(store.root_z)) * a + longint'(r.cell_z));
         if ($urandom_range(7) == 0) r.cell_y = r.cell_y + 32'(a);
      end else if ($urandom_range(15) == 0) begin
         r.cell_z = $urandom_range(1) ? 32'hFFFF_FFFF : 32'(a);
      end
      r.slice      = $urandom_range(span);
      r.row_v      = $urandom_range(span);
      r.word_index = (span >= WORD_BITS) ? $urandom_range(1) : ($urandom_range(15) == 0);
      r.data_word  = $urandom;
      r.mask_word  = $urandom;
      if ($urandom_range(3) == 0) r.data_word = r.data_word & r.mask_word;
      if (r.req_type == REQ_WRITE && $urandom_range(1)) begin
         r.data_word = r.data_word & ((span >= WORD_BITS) ? 16'hFFFF
                                      : 16'((32'd1 << (span + 1)) - 1));
      end
      return r;
   endfunction

   // Watchdog.
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      req_type_type r;
      logic [5:0]  axes   [6];
      logic [31:0] roots  [6][3];
      int          sent;

      axes  = '{6'd17, 6'd5, 6'd1, 6'd2, 6'd16, 6'd32};
      roots = '{'{32'd3, 32'hFFFF_FFFE, 32'd0},
                '{32'h7FFF_FFFF, 32'd100, 32'hFFFF_FFFF},
                '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
                '{32'h7FFF_FFFF, 32'd0, 32'd0},
                '{32'h8000_0000, 32'd7, 32'h0800_0000},
                '{32'd0, 32'd0, 32'd0}};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part at reset settings: full 32 cube, root at origin.
      r = plain(REQ_SET, 3'd0);                        // corner face at origin
      send_req(r);
      r = plain(REQ_SET, 3'd5);
      r.cell_x = 31; r.cell_y = 31; r.cell_z = 31;     // far corner
      send_req(r);
      r = plain(REQ_SET, 3'd2);
      r.cell_x = 32'hFFFF_FFFF;                        // below the cube
      send_req(r);
      r = plain(REQ_SET, 3'd3);
      r.cell_y = 32;                                   // past the cube
      send_req(r);
      r = plain(REQ_SET, 3'd6);                        // bad direction
      send_req(r);
      r = plain(REQ_HAS, 3'd0);                        // hit
      send_req(r);
      r = plain(REQ_HAS, 3'd5);
      r.cell_x = 31; r.cell_y = 31; r.cell_z = 30;     // miss
      send_req(r);
      r = plain(REQ_HAS, 3'd7);                        // bad direction, no error
      send_req(r);
      r = plain(REQ_HAS, 3'd1);
      r.cell_x = 32'h8000_0000;                        // far outside root
      send_req(r);
      r = plain(REQ_WRITE, 3'd4);
      r.slice = 31; r.row_v = 31; r.word_index = 1; r.data_word = 16'hFFFF;
      send_req(r);
      send_req(r);                                     // repeat write
      r.data_word = 16'h0000;                          // zero write is a no-op
      send_req(r);
      r = plain(REQ_READ, 3'd4);
      r.slice = 31; r.row_v = 31; r.word_index = 1;
      send_req(r);
      r.direction = 3'd6;                              // bad word address
      send_req(r);
      r = plain(REQ_REPLACE, 3'd4);
      r.slice = 31; r.row_v = 31; r.word_index = 1;
      r.data_word = 16'h00F0; r.mask_word = 16'h0FF0;
      send_req(r);
      r.mask_word = 16'h0000;                          // empty mask
      send_req(r);
      r = plain(REQ_EMIT, 3'd4);
      r.slice = 31; r.row_v = 31; r.word_index = 1; r.mask_word = 16'h8001;
      send_req(r);
      r.mask_word = 16'hFFFF;                          // nothing qualifies
      send_req(r);
      drain();

      // Shrink to 17: the far word has only one valid bit.
      configure(6'd17, 32'd0, 32'd0, 32'd0);
      r = plain(REQ_READ, 3'd0);
      send_req(r);
      r = plain(REQ_EMIT, 3'd0);                       // origin face emitted
      send_req(r);
      r = plain(REQ_WRITE, 3'd1);
      r.word_index = 1; r.data_word = 16'h0002;        // outside valid mask
      send_req(r);
      r.word_index = 1; r.data_word = 16'h0001;
      send_req(r);
      drain();

      // Axis size out of range: zero and above the maximum.
      configure(6'd0, 32'd0, 32'd0, 32'd0);
      send_req(plain(REQ_SET, 3'd0));
      send_req(plain(REQ_HAS, 3'd0));
      send_req(plain(REQ_EMIT, 3'd0));
      drain();
      configure(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_req(plain(REQ_READ, 3'd0));
      send_req(plain(REQ_HAS, 3'd0));
      drain();

      // Random phases across cube sizes and roots, overflow cases among them.
      sent = 0;
      for (int p = 0; p < 6; p++) begin
         configure(axes[p], roots[p][0], roots[p][1], roots[p][2]);
         for (int i = 0; i < 25; i++) begin
            if (sent < 50)       begin tx_idle_pct = 36; rx_idle_pct = 46; end
            else if (sent < 100) begin tx_idle_pct = 46; rx_idle_pct = 36; end
            else                 begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            if (p == 1 && i == 5) hold_go = 1;         // long receiver hold
            send_req(make_item());
            sent++;
         end
         drain();                                      // sender waits out all beats
      end

      drain();
      if (store.owed_beats.size() != 0) begin
         $error("%0d response beats never arrived", store.owed_beats.size());
         store.errors++;
      end
      if (store.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/vfbs_pkg.sv
sv/vfbs_if.sv
sv/vfbs_mem.sv
sv/vfbs_mac.sv
sv/voxel_face_bitmap_store_core.sv
sv/vfbs_checker.sv
verif/voxel_face_bitmap_store_core_tb.sv
